[rtl/core/hdr_peak_scan_and_half_encode_defines.svh]
// Assertion helpers shared by the RTL of the HDR peak scan and half encoder.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef HDR_PEAK_SCAN_AND_HALF_ENCODE_DEFINES_SVH
`define HDR_PEAK_SCAN_AND_HALF_ENCODE_DEFINES_SVH

// Same-cycle implication.
`define HPSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HPSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/hpse_pkg.sv]
// ----------------------------------------------------------------------------
// hpse_pkg
// Types, constants and float helpers of the HDR peak scan and half encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hpse_pkg;

  localparam int LANES = 3;

  // Item kinds
  localparam logic [1:0] KIND_SCAN   = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_ENCODE = 2'd2;

  // Result kinds
  localparam logic RES_SUMMARY = 1'b0;
  localparam logic RES_PIXEL   = 1'b1;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NONFINITE = 2'd1;
  localparam logic [1:0] STAT_NEG_WARN  = 2'd2;

  localparam logic [31:0] ONE_BITS       = 32'h3F80_0000;
  localparam logic [30:0] SAFE_MAX_RESET = 31'h477F_E000;
  localparam logic [15:0] ALPHA_HALF     = 16'h3C00;
  localparam logic [31:0] QNAN_DEFAULT   = 32'hFFC0_0000;
  // magnitude of -1e-6 in single precision
  localparam logic [30:0] NEG_WARN_MAG   = 31'h3586_37BD;

  typedef struct packed {
    logic busy;
    logic done;
  } fdiv_stat_t;

  typedef struct packed {
    logic [31:0] peak;
    logic [31:0] least;
    logic [31:0] nf_cnt;
    logic [31:0] neg_cnt;
  } scan_stat_t;

  // Clamp ceiling as used: out-of-range values fall back to 65504, zero to
  // the least denormal.
  function automatic logic [31:0] safe_max_eff(input logic [30:0] s);
    logic [30:0] v;
    v = s;
    if (v > SAFE_MAX_RESET) v = SAFE_MAX_RESET;
    if (v == 31'd0) v = 31'd1;
    return {1'b0, v};
  endfunction

  // Single to half, round to nearest even.
  function automatic logic [15:0] to_half(input logic [31:0] f);
    logic [15:0] sgn;
    logic [30:0] a;
    logic [30:0] hb;
    logic [15:0] h;
    logic [12:0] rem;
    logic [9:0]  m;
    logic [7:0]  e;
    logic [4:0]  sh;
    logic [23:0] mm;
    logic [23:0] hs;
    logic [23:0] rm;
    logic [23:0] hw;
    logic [15:0] r;
    sgn = {f[31], 15'd0};
    a   = f[30:0];
    hb  = '0;
    h   = '0;
    rem = '0;
    m   = '0;
    e   = '0;
    sh  = '0;
    mm  = '0;
    hs  = '0;
    rm  = '0;
    hw  = '0;
    if (a >= 31'h7F80_0000) begin
      m = a[22:13];
      if (a == 31'h7F80_0000) r = sgn | 16'h7C00;
      else r = sgn | 16'h7C00 | {6'd0, m} | {15'd0, (m == 10'd0)};
    end else if (a >= 31'h477F_F000) begin
      r = sgn | 16'h7C00;
    end else if (a >= 31'h3880_0000) begin
      hb  = (a - 31'h3800_0000) >> 13;
      h   = hb[15:0];
      rem = a[12:0];
      if (rem > 13'h1000 || (rem == 13'h1000 && h[0])) h = h + 16'd1;
      r = sgn | h;
    end else if (a <= 31'h3300_0000) begin
      r = sgn;
    end else begin
      // half subnormal
      e  = a[30:23];
      mm = {1'b1, a[22:0]};
      sh = 5'(8'd126 - e);
      hs = mm >> sh;
      rm = mm & ((24'd1 << sh) - 24'd1);
      hw = 24'd1 << (sh - 5'd1);
      if (rm > hw || (rm == hw && hs[0])) hs = hs + 24'd1;
      r = sgn | hs[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/hpse_in_if.sv]
// ----------------------------------------------------------------------------
// hpse_in_if
// Input item channel: valid/ready with kind and three float samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] red_sample;
  logic [31:0] green_sample;
  logic [31:0] blue_sample;

  modport source (output valid, kind, red_sample, green_sample, blue_sample,
                  input ready);
  modport sink (input valid, kind, red_sample, green_sample, blue_sample,
                output ready);
endinterface

`default_nettype wire

[rtl/core/hpse_out_if.sv]
// ----------------------------------------------------------------------------
// hpse_out_if
// Result item channel: valid/ready with summary or encoded pixel fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpse_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [63:0] pixel_half;
  logic [1:0]  status;
  logic [31:0] nonfinite_total;
  logic [31:0] negative_total;
  logic [31:0] minimum_sample;
  logic [31:0] decode_scale;

  modport source (output valid, result_kind, pixel_half, status, nonfinite_total,
                  negative_total, minimum_sample, decode_scale, input ready);
  modport sink (input valid, result_kind, pixel_half, status, nonfinite_total,
                negative_total, minimum_sample, decode_scale, output ready);
endinterface

`default_nettype wire

[rtl/core/hpse_fdiv.sv]
// ----------------------------------------------------------------------------
// hpse_fdiv
// One lane: iterative single-precision divider, one quotient bit per cycle,
// round to nearest even, full denormal support.
// ----------------------------------------------------------------------------
`default_nettype none

module hpse_fdiv
  import hpse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output fdiv_stat_t       stat,
  output logic [31:0]      q
);

  localparam logic [2:0] FD_IDLE = 3'd0;
  localparam logic [2:0] FD_NORM = 3'd1;
  localparam logic [2:0] FD_DIV  = 3'd2;
  localparam logic [2:0] FD_RND  = 3'd3;
  localparam logic [2:0] FD_DONE = 3'd4;
  localparam int         QBITS   = 26;

  logic [2:0]         state_r, state_nxt;
  logic               sign_r;
  logic [23:0]        ma_r, mb_r;
  logic signed [10:0] ea_r, eb_r;
  logic [24:0]        rem_r;
  logic [25:0]        quo_r;
  logic [4:0]         cnt_r;
  logic [31:0]        q_r;

  // operand classes
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, special;
  logic [31:0] special_q;

  always_comb begin
    a_nan  = (&a[30:23]) && (|a[22:0]);
    b_nan  = (&b[30:23]) && (|b[22:0]);
    a_inf  = (&a[30:23]) && !(|a[22:0]);
    b_inf  = (&b[30:23]) && !(|b[22:0]);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    special = a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
    priority if (a_nan) special_q = a | 32'h0040_0000;
    else if (b_nan) special_q = b | 32'h0040_0000;
    else if ((a_inf && b_inf) || (a_zero && b_zero)) special_q = QNAN_DEFAULT;
    else if (a_inf || b_zero) special_q = {a[31] ^ b[31], 31'h7F80_0000};
    else special_q = {a[31] ^ b[31], 31'd0};
  end

  // restoring division step
  logic [25:0] diff;
  logic        ge;
  logic [24:0] rem_keep;

  always_comb begin
    diff     = {1'b0, rem_r} - {2'b0, mb_r};
    ge       = !diff[25];
    rem_keep = ge ? diff[24:0] : rem_r;
  end

  // normalize and round the finished quotient
  logic [25:0]        mq;
  logic signed [10:0] be, sh_w, be_m1;
  logic [4:0]         sh;
  logic [25:0]        hq;
  logic               g, stk;
  logic [24:0]        hr;
  logic [31:0]        mag;
  logic [31:0]        rnd_q;

  always_comb begin
    mq    = quo_r[25] ? quo_r : {quo_r[24:0], 1'b0};
    be    = ea_r - eb_r + 11'sd127 - (quo_r[25] ? 11'sd0 : 11'sd1);
    sh_w  = 11'sd3 - be;
    be_m1 = be - 11'sd1;
    if (be >= 11'sd1) sh = 5'd2;
    else if (sh_w > 11'sd27) sh = 5'd27;
    else sh = sh_w[4:0];
    hq  = mq >> sh;
    g   = hq[0] ? 1'b0 : 1'b0;
    g   = (mq >> (sh - 5'd1)) != 26'd0 ? ((mq >> (sh - 5'd1)) & 26'd1) != 26'd0 : 1'b0;
    stk = ((mq & ((26'd1 << (sh - 5'd1)) - 26'd1)) != 26'd0) || (rem_r != 25'd0);
    hr  = hq[24:0] + {24'd0, g && (stk || hq[0])};
    if (be >= 11'sd1) mag = {1'b0, be_m1[7:0], 23'd0} + {7'd0, hr};
    else mag = {7'd0, hr};
    if (be >= 11'sd255) rnd_q = {sign_r, 31'h7F80_0000};
    else rnd_q = {sign_r, mag[30:0]};
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FD_IDLE, FD_DONE: if (start) state_nxt = special ? FD_DONE : FD_NORM;
      FD_NORM: if (ma_r[23] && mb_r[23]) state_nxt = FD_DIV;
      FD_DIV:  if (cnt_r == 5'(QBITS - 1)) state_nxt = FD_RND;
      FD_RND:  state_nxt = FD_DONE;
      default: state_nxt = FD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= FD_IDLE;
    else state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      FD_IDLE, FD_DONE: begin
        if (start) begin
          sign_r <= a[31] ^ b[31];
          ma_r   <= {a[30:23] != 8'd0, a[22:0]};
          mb_r   <= {b[30:23] != 8'd0, b[22:0]};
          ea_r   <= {3'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]};
          eb_r   <= {3'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]};
          q_r    <= special_q;
        end
      end
      FD_NORM: begin
        if (!ma_r[23]) begin
          ma_r <= {ma_r[22:0], 1'b0};
          ea_r <= ea_r - 11'sd1;
        end else if (!mb_r[23]) begin
          mb_r <= {mb_r[22:0], 1'b0};
          eb_r <= eb_r - 11'sd1;
        end else begin
          rem_r <= {1'b0, ma_r};
          quo_r <= '0;
          cnt_r <= '0;
        end
      end
      FD_DIV: begin
        rem_r <= {rem_keep[23:0], 1'b0};
        quo_r <= {quo_r[24:0], ge};
        cnt_r <= cnt_r + 5'd1;
      end
      FD_RND: q_r <= rnd_q;
      default: ;
    endcase
  end

  assign stat.busy = (state_r == FD_NORM) || (state_r == FD_DIV) || (state_r == FD_RND);
  assign stat.done = (state_r == FD_DONE);
  assign q         = q_r;

endmodule

`default_nettype wire

[rtl/core/hpse_scan.sv]
// ----------------------------------------------------------------------------
// hpse_scan
// Scan statistics: per-lane sample classification merged into saturating
// counts, peak and most negative value.
// ----------------------------------------------------------------------------
`default_nettype none

module hpse_scan
  import hpse_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   scan_en,
  input  wire logic                   clear_en,
  input  wire logic [LANES-1:0][31:0] samples,
  output scan_stat_t                  st
);

  logic [31:0] peak_r, least_r, nf_r, neg_r;
  logic [31:0] peak_nxt, least_nxt, nf_nxt, neg_nxt;
  logic [1:0]  nf_add, neg_add;
  logic [32:0] nf_sum, neg_sum;

  // merge the lanes' findings
  always_comb begin
    peak_nxt  = peak_r;
    least_nxt = least_r;
    nf_add    = '0;
    neg_add   = '0;
    for (int i = 0; i < LANES; i++) begin
      if (&samples[i][30:23]) begin
        nf_add = nf_add + 2'd1;
      end else if (samples[i][31] && samples[i][30:0] != 31'd0) begin
        neg_add = neg_add + 2'd1;
        if (samples[i][30:0] > least_nxt[30:0]) least_nxt = samples[i];
      end else if (!samples[i][31] && samples[i] > peak_nxt) begin
        peak_nxt = samples[i];
      end
    end
    nf_sum  = {1'b0, nf_r} + {31'd0, nf_add};
    neg_sum = {1'b0, neg_r} + {31'd0, neg_add};
    nf_nxt  = nf_sum[32] ? '1 : nf_sum[31:0];
    neg_nxt = neg_sum[32] ? '1 : neg_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_en) begin
      peak_r  <= '0;
      least_r <= '0;
      nf_r    <= '0;
      neg_r   <= '0;
    end else if (scan_en) begin
      peak_r  <= peak_nxt;
      least_r <= least_nxt;
      nf_r    <= nf_nxt;
      neg_r   <= neg_nxt;
    end
  end

  assign st.peak    = peak_r;
  assign st.least   = least_r;
  assign st.nf_cnt  = nf_r;
  assign st.neg_cnt = neg_r;

endmodule

`default_nettype wire

[rtl/core/hdr_peak_scan_and_half_encode.sv]
// The block takes one item at a time. A scan item is absorbed in the cycle it
// is accepted. A finish item occupies divider lane 0, an encode item all three
// divider lanes: a normalizing shift for each leading zero of a denormal
// operand (none for normal operands), a setup step, the bit-serial quotient of
// 26 bits, then round, merge and the output register. The next item is taken
// while a finished result still waits in the output register.
// ----------------------------------------------------------------------------
// hdr_peak_scan_and_half_encode
// HDR peak scan and half-precision pixel encoder top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hdr_peak_scan_and_half_encode
  import hpse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  hpse_in_if.sink          in_ch,
  hpse_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_wdata
);

`include "hdr_peak_scan_and_half_encode_defines.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;

  logic [1:0]  state_r;
  logic [30:0] smax_r;
  logic [31:0] scale_r;
  logic        op_finish_r;
  logic [LANES-1:0] need_r;

  // held summary of a finish item
  logic [1:0]  sum_status_r;
  logic [31:0] sum_nf_r, sum_neg_r, sum_least_r;

  // output register
  logic        out_valid_r, out_kind_r;
  logic [63:0] out_pixel_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_nf_r, out_neg_r, out_min_r, out_scale_r;

  logic        accept, is_scan, is_finish, is_encode, out_free, all_done;
  logic [31:0] smax_eff;
  logic [1:0]  status_now;
  scan_stat_t  scan_st;
  logic [LANES-1:0][31:0] samples;
  logic [LANES-1:0][31:0] lane_a;
  logic [LANES-1:0]       lane_start, done_vec;
  logic [31:0]            lane_q [LANES];
  fdiv_stat_t             lane_stat [LANES];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_scan     = accept && (in_ch.kind == KIND_SCAN);
  assign is_finish   = accept && (in_ch.kind == KIND_FINISH);
  assign is_encode   = accept && (in_ch.kind == KIND_ENCODE);
  assign smax_eff    = safe_max_eff(smax_r);
  assign samples     = {in_ch.blue_sample, in_ch.green_sample, in_ch.red_sample};
  assign out_free    = !out_valid_r || out_ch.ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) smax_r <= SAFE_MAX_RESET;
    else if (cfg_we) smax_r <= cfg_wdata;
  end

  // statistics
  hpse_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .scan_en  (is_scan),
    .clear_en (is_finish),
    .samples  (samples),
    .st       (scan_st)
  );

  always_comb begin
    if (scan_st.nf_cnt != 32'd0) status_now = STAT_NONFINITE;
    else if (scan_st.neg_cnt != 32'd0 && scan_st.least[31] &&
             scan_st.least[30:0] > NEG_WARN_MAG) status_now = STAT_NEG_WARN;
    else status_now = STAT_OK;
  end

  // divider lanes; lane 0 also computes peak / safe maximum
  always_comb begin
    lane_a     = samples;
    lane_start = '0;
    if (is_finish) begin
      lane_a[0]     = scan_st.peak;
      lane_start[0] = 1'b1;
    end
    if (is_encode) lane_start = '1;
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    hpse_fdiv u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (lane_start[g]),
      .a     (lane_a[g]),
      .b     (is_finish ? smax_eff : scale_r),
      .stat  (lane_stat[g]),
      .q     (lane_q[g])
    );
    assign done_vec[g] = lane_stat[g].done;
  end

  assign all_done = &(~need_r | done_vec);

  // merge: clamp, half encode and pack, or finish the scale
  logic [LANES-1:0][15:0] halves;
  logic [31:0] v_cl [LANES];
  logic [31:0] new_scale;
  logic        v_nan;

  always_comb begin
    v_nan = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      v_nan   = (&lane_q[i][30:23]) && (|lane_q[i][22:0]);
      v_cl[i] = lane_q[i];
      if (!v_nan && lane_q[i][31] && lane_q[i][30:0] != 31'd0) v_cl[i] = '0;
      else if (!v_nan && !lane_q[i][31] && lane_q[i] > smax_eff) v_cl[i] = smax_eff;
      halves[i] = to_half(v_cl[i]);
    end
    new_scale = (lane_q[0] > ONE_BITS) ? lane_q[0] : ONE_BITS;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scale_r     <= ONE_BITS;
      out_valid_r <= 1'b0;
    end else begin
      // result register: loaded by the merge, dropped once taken
      if (state_r == ST_MERGE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE:  if (is_finish || is_encode) state_r <= ST_RUN;
        ST_RUN:   if (all_done) state_r <= ST_MERGE;
        ST_MERGE: begin
          if (out_free) begin
            if (op_finish_r) scale_r <= new_scale;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (is_finish || is_encode) begin
      op_finish_r <= is_finish;
      need_r      <= is_finish ? LANES'(1) : '1;
    end
    if (is_finish) begin
      sum_status_r <= status_now;
      sum_nf_r     <= scan_st.nf_cnt;
      sum_neg_r    <= scan_st.neg_cnt;
      sum_least_r  <= scan_st.least;
    end
    if (state_r == ST_MERGE && out_free) begin
      if (op_finish_r) begin
        out_kind_r   <= RES_SUMMARY;
        out_pixel_r  <= '0;
        out_status_r <= sum_status_r;
        out_nf_r     <= sum_nf_r;
        out_neg_r    <= sum_neg_r;
        out_min_r    <= sum_least_r;
        out_scale_r  <= new_scale;
      end else begin
        out_kind_r   <= RES_PIXEL;
        out_pixel_r  <= {ALPHA_HALF, halves[2], halves[1], halves[0]};
        out_status_r <= STAT_OK;
        out_nf_r     <= '0;
        out_neg_r    <= '0;
        out_min_r    <= '0;
        out_scale_r  <= scale_r;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_kind     = out_kind_r;
  assign out_ch.pixel_half      = out_pixel_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.nonfinite_total = out_nf_r;
  assign out_ch.negative_total  = out_neg_r;
  assign out_ch.minimum_sample  = out_min_r;
  assign out_ch.decode_scale    = out_scale_r;

  `HPSE_ASSERT_IMPL(a_merge_lanes_done, state_r == ST_MERGE, all_done, "merge early")
  `HPSE_ASSERT_IMPL(a_scale_min, 1'b1, !scale_r[31] && scale_r >= ONE_BITS, "scale below one")
  `HPSE_ASSERT_IMPL(a_pixel_scale, out_valid_r && out_kind_r == RES_PIXEL,
                    out_scale_r == scale_r, "pixel scale stale")
  `HPSE_ASSERT_NEXT(a_start_runs, is_finish || is_encode, state_r == ST_RUN, "no run")

endmodule

`default_nettype wire
